// ===== src/error_diffusion_dither_rgb_core_defines.svh =====
// Assertion macros for the error diffusion dither core.
// No dependencies; included by the top level, which provides clk and rst.
`ifndef ERROR_DIFFUSION_DITHER_RGB_CORE_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_RGB_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define EDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/edd_pkg.sv =====
// Shared types and constants for the error diffusion dither core.
// No dependencies.
package edd_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [7:0]  THRESHOLD_RESET    = 8'd127;
  localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1024;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  // Channel levels
  localparam logic [7:0] LEVEL_LOW  = 8'd0;
  localparam logic [7:0] LEVEL_HIGH = 8'd255;

  // One line store word: three 8-bit channel errors, red in the top byte
  localparam int NUM_CH = 3;
  localparam int LINE_W = 24;

  typedef struct packed {
    logic [7:0] pixel_r;
    logic [7:0] pixel_g;
    logic [7:0] pixel_b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic       frame_end;
  } result_t;

  // Per-channel diffusion state carried along a row
  typedef struct packed {
    logic [7:0] pend_left;  // down terms gathered for the previous column
    logic [3:0] pend_here;  // 1/16 term for the current column
    logic [6:0] carry;      // 7/16 term for the next pixel
  } chan_state_t;

endpackage

// ===== src/error_diffusion_dither_rgb_core.sv =====
// Top level of the RGB error diffusion dither core.
// Depends on edd_pkg, edd_ram, edd_chan and error_diffusion_dither_rgb_core_defines.svh.

// Binarizes a raster-order RGB stream to 0/255 per channel with Floyd-Steinberg
// style error diffusion (non-negative error only). One pixel item is accepted
// per clock, sustained, while the result output is not stalled. The pixel and
// the read of the next-row error line store are registered on acceptance, and
// the arithmetic runs into the output register when that pixel moves on. The
// line store is split into even and odd column RAMs so that the last pixel of
// a row can finish two columns at once. A fill mark tracks which columns have
// been written since reset, so no clearing pass is needed. Write threshold,
// frame_width and frame_height only while no item is in flight; the counters
// pick up new geometry on the next pixel.
`include "error_diffusion_dither_rgb_core_defines.svh"

module error_diffusion_dither_rgb_core #(
  parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  edd_pkg::pixel_t                   pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output edd_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [edd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int HALF = (MAX_WIDTH + 1) / 2;
  localparam int HAW  = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int LW   = edd_pkg::LINE_W;

  // Configuration registers
  logic [7:0]  threshold;
  logic [10:0] frame_width;
  logic [15:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= edd_pkg::THRESHOLD_RESET;
      frame_width  <= edd_pkg::FRAME_WIDTH_RESET;
      frame_height <= edd_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edd_pkg::REG_THRESHOLD:    threshold    <= cfg_data[7:0];
        edd_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        edd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;

  always_comb begin
    if (frame_width == 11'd0) begin
      eff_w = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
  end

  assign eff_h = (frame_height == 16'd0) ? 16'd1 : frame_height;

  // Handshake and pipeline control
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  // Raster position of the next pixel
  logic [CW-1:0] col;
  logic [15:0]   row;
  logic          row_last;
  logic          frame_last;

  assign row_last   = (WW'(col) + WW'(1)) >= eff_w;
  assign frame_last = row_last && ((17'(row) + 17'd1) >= 17'(eff_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_last) begin
        col <= '0;
        row <= frame_last ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Stage 1 registers (pixel waiting on line store data)
  edd_pkg::pixel_t s1_pix;
  logic [CW-1:0]   s1_x;
  logic            s1_row_last;
  logic            s1_frame_last;
  logic            s1_first_row;
  logic            s1_filled;
  logic            s1_fwd;
  logic [LW-1:0]   s1_fwd_data;

  // Line store write words from the channel datapath
  logic [7:0]    q     [edd_pkg::NUM_CH];
  logic [7:0]    wr_lo [edd_pkg::NUM_CH];
  logic [7:0]    wr_hi [edd_pkg::NUM_CH];
  logic [LW-1:0] lo_word;
  logic [LW-1:0] hi_word;
  logic [CW-1:0] x_lo;

  assign lo_word = {wr_lo[0], wr_lo[1], wr_lo[2]};
  assign hi_word = {wr_hi[0], wr_hi[1], wr_hi[2]};
  assign x_lo    = s1_x - CW'(1);

  // Forward a write landing on the entry read at the same edge
  logic fwd_lo;
  logic fwd_hi;
  logic [CW:0] fill;

  assign fwd_lo = s1_adv && (s1_x != '0) && (x_lo == col);
  assign fwd_hi = s1_adv && s1_row_last && (s1_x == col);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix        <= pixel;
      s1_x          <= col;
      s1_row_last   <= row_last;
      s1_frame_last <= frame_last;
      s1_first_row  <= (row == 16'd0);
      s1_filled     <= (CW + 1)'(col) < fill;
      s1_fwd        <= fwd_lo || fwd_hi;
      s1_fwd_data   <= fwd_hi ? hi_word : lo_word;
    end
  end

  // Fill mark: columns below it have been written since reset
  logic [CW:0] written_cnt;

  assign written_cnt = s1_row_last ? (CW + 1)'(s1_x) + (CW + 1)'(1) : (CW + 1)'(s1_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (s1_adv && (written_cnt > fill)) begin
      fill <= written_cnt;
    end
  end

  // Even and odd column line stores
  logic          we_even;
  logic          we_odd;
  logic [HAW-1:0] wa_even;
  logic [HAW-1:0] wa_odd;
  logic [HAW-1:0] ra;
  logic [LW-1:0] wd_even;
  logic [LW-1:0] wd_odd;
  logic [LW-1:0] rd_even;
  logic [LW-1:0] rd_odd;

  assign we_even = s1_adv && (s1_x[0] || s1_row_last);
  assign we_odd  = s1_adv && (s1_x[0] ? s1_row_last : (s1_x != '0));
  assign wa_even = HAW'(s1_x >> 1);
  assign wa_odd  = s1_x[0] ? HAW'(s1_x >> 1) : HAW'(x_lo >> 1);
  assign wd_even = s1_x[0] ? lo_word : hi_word;
  assign wd_odd  = s1_x[0] ? hi_word : lo_word;
  assign ra      = HAW'(col >> 1);

  edd_ram #(
    .WIDTH (LW),
    .DEPTH (HALF)
  ) u_ram_even (
    .clk     (clk),
    .we      (we_even),
    .wr_addr (wa_even),
    .wr_data (wd_even),
    .re      (accept),
    .rd_addr (ra),
    .rd_data (rd_even)
  );

  edd_ram #(
    .WIDTH (LW),
    .DEPTH (HALF)
  ) u_ram_odd (
    .clk     (clk),
    .we      (we_odd),
    .wr_addr (wa_odd),
    .wr_data (wd_odd),
    .re      (accept),
    .rd_addr (ra),
    .rd_data (rd_odd)
  );

  // Error received from the row above
  logic [LW-1:0] above_word;

  always_comb begin
    if (s1_first_row) begin
      above_word = '0;
    end else if (s1_fwd) begin
      above_word = s1_fwd_data;
    end else if (s1_filled) begin
      above_word = s1_x[0] ? rd_odd : rd_even;
    end else begin
      above_word = '0;
    end
  end

  // Channel datapaths: index 0 red, 1 green, 2 blue
  edd_pkg::chan_state_t cstate      [edd_pkg::NUM_CH];
  edd_pkg::chan_state_t cstate_next [edd_pkg::NUM_CH];
  logic [7:0]           pix_ch      [edd_pkg::NUM_CH];

  assign pix_ch[0] = s1_pix.pixel_r;
  assign pix_ch[1] = s1_pix.pixel_g;
  assign pix_ch[2] = s1_pix.pixel_b;

  for (genvar c = 0; c < edd_pkg::NUM_CH; c++) begin : g_ch
    edd_chan u_chan (
      .pix        (pix_ch[c]),
      .above      (above_word[LW-1-8*c -: 8]),
      .thr        (threshold),
      .row_last   (s1_row_last),
      .state      (cstate[c]),
      .q          (q[c]),
      .wr_lo      (wr_lo[c]),
      .wr_hi      (wr_hi[c]),
      .state_next (cstate_next[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        cstate[c] <= '0;
      end else if (s1_adv) begin
        cstate[c] <= cstate_next[c];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.out_r     <= q[0];
      result.out_g     <= q[1];
      result.out_b     <= q[2];
      result.frame_end <= s1_frame_last;
    end
  end

  // Checks
  logic carry_clear;
  logic green_binary;

  assign carry_clear  = (cstate[0].carry == '0) && (cstate[1].carry == '0) &&
                        (cstate[2].carry == '0);
  assign green_binary = (result.out_g == edd_pkg::LEVEL_LOW) ||
                        (result.out_g == edd_pkg::LEVEL_HIGH);

  `EDD_ASSERT_NOW(a_fwd_col_zero, s1_valid && s1_fwd, s1_x == '0, "forward off column zero")
  `EDD_ASSERT_NEXT(a_row_end_clear, s1_adv && s1_row_last, carry_clear, "carry survived row end")
  `EDD_ASSERT_NOW(a_out_level, result_valid, green_binary, "green not binary")

endmodule

// ===== src/edd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/edd_chan.sv =====
// One color channel: saturating adjust, threshold, and 7/3/5/1 diffusion terms.
// Depends on edd_pkg.
module edd_chan (
  input  logic                [7:0] pix,
  input  logic                [7:0] above,
  input  logic                [7:0] thr,
  input  logic                      row_last,
  input  edd_pkg::chan_state_t      state,
  output logic                [7:0] q,
  output logic                [7:0] wr_lo,
  output logic                [7:0] wr_hi,
  output edd_pkg::chan_state_t      state_next
);

  logic [9:0]  sum;
  logic [7:0]  adj;
  logic [7:0]  err;
  logic [10:0] p3;
  logic [10:0] p5;
  logic [10:0] p7;
  logic [7:0]  down_here;

  // Adjusted value, saturated at full scale
  assign sum = 10'(pix) + 10'(state.carry) + 10'(above);
  assign adj = (sum > 10'd255) ? 8'd255 : sum[7:0];

  // Quantize; only a low output leaves an error behind
  always_comb begin
    if (adj >= thr) begin
      q   = edd_pkg::LEVEL_HIGH;
      err = 8'd0;
    end else begin
      q   = edd_pkg::LEVEL_LOW;
      err = adj;
    end
  end

  // Weighted terms, each truncated on its own
  assign p3 = 11'(err) * 11'd3;
  assign p5 = 11'(err) * 11'd5;
  assign p7 = 11'(err) * 11'd7;

  // Down-left term completes the previous column; down term joins this one
  assign wr_lo     = state.pend_left + 8'(p3[9:4]);
  assign down_here = 8'(state.pend_here) + 8'(p5[10:4]);
  assign wr_hi     = down_here;

  always_comb begin
    if (row_last) begin
      state_next = '0;
    end else begin
      state_next.pend_left = down_here;
      state_next.pend_here = err[7:4];
      state_next.carry     = p7[10:4];
    end
  end

endmodule

// ===== verif/error_diffusion_dither_rgb_core_test.sv =====
// Self-checking testbench for error_diffusion_dither_rgb_core: random-timed pixel stream,
// an in-bench dither predictor and an in-order result check.
// Depends on edd_pkg and the core RTL.
module error_diffusion_dither_rgb_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import edd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_PAUSE = 4;

  typedef enum int {STY_UNIFORM, STY_NEAR, STY_EDGES, STY_FLAT} level_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  error_diffusion_dither_rgb_core u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: registers, error line, row carries, raster position
  logic [7:0]  thresh_reg;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  err_line [MAX_W][3];
  logic [7:0]  carry_term [3];
  logic [7:0]  pend_left [3];
  logic [7:0]  pend_here [3];
  int unsigned col_pos;
  int unsigned row_pos;

  pixel_t  pixel_backlog [$];
  result_t expected_dither [$];
  int unsigned pixels_in = 0;
  int unsigned results_checked = 0;
  int unsigned frame_ends = 0;
  int unsigned mismatches = 0;
  int unsigned settings_count = 0;
  bit no_idle = 1'b0;

  function automatic void clear_predictor();
    thresh_reg = THRESHOLD_RESET;
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      for (int c = 0; c < 3; c++) err_line[i][c] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      carry_term[c] = '0;
      pend_left[c] = '0;
      pend_here[c] = '0;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Dither one pixel and advance the diffusion state
  function automatic result_t dither_pixel(pixel_t p);
    int unsigned w, h, x, v, above, e;
    bit row_last, frame_last;
    logic [7:0] chan_in [3];
    logic [7:0] chan_out [3];
    result_t r;
    w = eff_width();
    h = eff_height();
    x = col_pos;
    row_last = (x + 1 >= w);
    frame_last = row_last && (row_pos + 1 >= h);
    chan_in[0] = p.pixel_r;
    chan_in[1] = p.pixel_g;
    chan_in[2] = p.pixel_b;
    for (int c = 0; c < 3; c++) begin
      above = (row_pos != 0 && x < MAX_W) ? err_line[x][c] : 0;
      v = chan_in[c] + carry_term[c] + above;
      if (v > 255) v = 255;
      if (v >= thresh_reg) begin
        chan_out[c] = LEVEL_HIGH;
        e = 0;
      end else begin
        chan_out[c] = LEVEL_LOW;
        e = v;
      end
      // previous column now has all three of its contributors
      if (x > 0 && x - 1 < MAX_W) err_line[x-1][c] = 8'(pend_left[c] + ((e * 3) >> 4));
      if (row_last) begin
        if (x < MAX_W) err_line[x][c] = 8'(pend_here[c] + ((e * 5) >> 4));
        pend_left[c] = '0;
        pend_here[c] = '0;
        carry_term[c] = '0;
      end else begin
        pend_left[c] = 8'(pend_here[c] + ((e * 5) >> 4));
        pend_here[c] = 8'(e >> 4);
        carry_term[c] = 8'((e * 7) >> 4);
      end
    end
    if (row_last) begin
      col_pos = 0;
      row_pos = frame_last ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = (x + 1) & 11'h7FF;
    end
    r.out_r = chan_out[0];
    r.out_g = chan_out[1];
    r.out_b = chan_out[2];
    r.frame_end = frame_last;
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_level(level_style_t style, int unsigned base);
    int signed lvl;
    case (style)
      STY_NEAR: lvl = int'(thresh_reg) + $urandom_range(0, 16) - 8;
      STY_EDGES: lvl = $urandom_range(0, 1) ? 255 - $urandom_range(0, 15) : $urandom_range(0, 15);
      STY_FLAT: lvl = int'(base) + $urandom_range(0, 6) - 3;
      default: lvl = $urandom_range(0, 255);
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return lvl[7:0];
  endfunction

  // Sender: one item per handshake, random gaps between items
  int unsigned send_gap;
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      send_gap <= 0;
    end else if (!pixel_valid || !pixel_stall) begin
      if (send_gap != 0) begin
        pixel_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_backlog.size() != 0) begin
        pixel <= pixel_backlog.pop_front();
        pixel_valid <= 1'b1;
        send_gap <= idle_len();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Accepted pixels feed the predictor
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      expected_dither.push_back(dither_pixel(pixel));
      pixels_in <= pixels_in + 1;
    end
  end

  // Receiver stall: random runs, plus one long hold while pixels keep coming
  int unsigned stall_left;
  bit hold_done;
  always @(posedge clk) begin
    int unsigned run;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pixels_in >= HOLD_AT && pixel_backlog.size() > 16) begin
      result_stall <= 1'b1;
      stall_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      run = idle_len();
      result_stall <= (run != 0);
      stall_left <= run;
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_dither.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected item: r=%h g=%h b=%h end=%b", $realtime,
                   result.out_r, result.out_g, result.out_b, result.frame_end);
      end else begin
        want = expected_dither.pop_front();
        results_checked++;
        if (want.frame_end) frame_ends++;
        if (result.out_r !== want.out_r || result.out_g !== want.out_g ||
            result.out_b !== want.out_b || result.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] item %0d: expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                     $realtime, results_checked, want.out_r, want.out_g, want.out_b,
                     want.frame_end, result.out_r, result.out_g, result.out_b,
                     result.frame_end);
        end
      end
    end
  end

  // Write one register; the caller lowers the write enable
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_THRESHOLD: thresh_reg = val[7:0];
      REG_FRAME_WIDTH: width_reg = val[10:0];
      REG_FRAME_HEIGHT: height_reg = val[15:0];
      default: ;
    endcase
  endtask

  // Write the selected registers; upper threshold bits carry junk
  task automatic apply_settings(logic [2:0] sel, logic [7:0] thr, logic [10:0] wid,
                                logic [15:0] hgt);
    logic [15:0] junk;
    junk = 16'($urandom);
    if (sel[0]) write_reg(REG_THRESHOLD, {junk[15:8], thr});
    if (sel[1]) write_reg(REG_FRAME_WIDTH, {5'd0, wid});
    if (sel[2]) write_reg(REG_FRAME_HEIGHT, hgt);
    if (sel != 0) begin
      @(posedge clk);
      cfg_we <= 1'b0;
    end
    settings_count++;
  endtask

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    p.pixel_r = r;
    p.pixel_g = g;
    p.pixel_b = b;
    pixel_backlog.push_back(p);
  endtask

  // Wait until every item is accepted and answered, then let the pipe settle
  task automatic drain();
    while (pixel_backlog.size() != 0 || pixel_valid || expected_dither.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  initial begin
    int unsigned random_total, n, area, base;
    logic [7:0] thr;
    logic [10:0] wid;
    logic [15:0] hgt;
    level_style_t style;
    clear_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Small frame: extremes, alternating bits, values around the threshold;
    // the unused index must change nothing
    write_reg(REG_UNUSED, 16'hFFFF);
    apply_settings(3'b111, 8'd127, 11'd4, 16'd2);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h55, 8'hAA, 8'h55);
    push_pixel(8'hAA, 8'h55, 8'hAA);
    push_pixel(8'd126, 8'd127, 8'd128);
    push_pixel(8'd100, 8'd60, 8'd20);
    push_pixel(8'd110, 8'd80, 8'd0);
    push_pixel(8'd120, 8'd126, 8'd1);
    drain();
    // One-pixel frames with the highest threshold
    apply_settings(3'b111, 8'd255, 11'd1, 16'd1);
    push_pixel(8'd254, 8'd255, 8'd0);
    push_pixel(8'd255, 8'd254, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd254);
    drain();
    // Zero threshold, zero width and height count as one
    apply_settings(3'b111, 8'd0, 11'd0, 16'd0);
    push_pixel(8'd0, 8'd1, 8'd2);
    push_pixel(8'd0, 8'd0, 8'd0);
    drain();
    // Width over the line store size, tallest frame
    apply_settings(3'b111, 8'd200, 11'd2047, 16'd65535);
    for (int i = 0; i < 6; i++) push_pixel(8'd190, 8'd150, 8'd199);
    drain();
    // Narrower width mid-row: the row ends at once
    apply_settings(3'b111, 8'd100, 11'd3, 16'd3);
    for (int i = 0; i < 7; i++) push_pixel(8'd70, 8'd90, 8'd40);
    drain();

    // Random phases
    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: thr = 8'd0;
        1: thr = 8'd255;
        default: thr = 8'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 11))
        0: wid = 11'd0;
        1: wid = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
        default: wid = 11'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 11))
        0: hgt = 16'd0;
        1: hgt = 16'd65535;
        default: hgt = 16'($urandom_range(1, 5));
      endcase
      apply_settings(3'($urandom_range(0, 7)), thr, wid, hgt);
      no_idle = ($urandom_range(0, 4) == 0);
      style = level_style_t'($urandom_range(0, 3));
      base = $urandom_range(0, 255);
      area = eff_width() * eff_height();
      if (area <= 48 && $urandom_range(0, 1)) n = area * $urandom_range(1, 2);
      else n = $urandom_range(15, 80);
      for (int i = 0; i < n; i++)
        push_pixel(pick_level(style, base), pick_level(style, base), pick_level(style, base));
      random_total += n;
      drain();
    end
    no_idle = 1'b0;
    repeat (8) @(posedge clk);

    $display("Covered %0d pixels under %0d register settings; %0d results checked,",
             pixels_in, settings_count, results_checked);
    $display("%0d of them frame ends, %0d mismatches.", frame_ends, mismatches);
    if (mismatches == 0 && expected_dither.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #8000000;
    $display("Timeout with %0d results still expected.", expected_dither.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
